/* sv/apts_pkg.sv */
// Shared types and constants for the aging priority tick scheduler.
// Holds the opcode codes, the slot row layout, the sequencer states and the slot update result.
// No dependencies.
package apts_pkg;

    localparam int TIME_W   = 24;
    localparam int PRIO_W   = 32;
    localparam int BURST_W  = 16;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;
    localparam int OP_W     = 2;
    localparam int SUM_W    = 32;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_TUSER_W = 2;

    typedef struct packed {
        logic [BURST_W-1:0] arrival;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] remaining;
        logic [PRIO_W-1:0]  prio;
    } t_row;

    typedef struct packed {
        logic               ready;
        logic               serve;
        logic               fin;
        logic [PRIO_W-1:0]  prio_next;
        logic [BURST_W-1:0] rem_next;
        logic [TIME_W-1:0]  wait_val;
    } t_slot_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_DONE
    } t_state;

endpackage

/* sv/aging_priority_tick_scheduler_unit.sv */
// Top level of the aging priority tick scheduler: sequencer, slot RAM and status registers.
// Depends on apts_pkg, apts_ram and apts_slot_alu.
//
//  Channel    Direction  Handshake               Content
//  s_axis     in         tvalid/tready           one command word (load, tick, restart)
//  m_axis     out        tvalid/tready           one status word per command
//  cfg        in         valid/ready             process_count write
//
// A tick for N used slots passes through accept, one RAM fetch, one update step per slot
// through the shared update unit, and a final step that posts the result. Load, restart and
// unused codes go from accept straight to posting the result. The pass is bound by the single
// RAM read port. Reset is synchronous and clears all slot valid bits at once; there is no
// clearing pass. A stalled output word holds the block in its final state until taken.
module aging_priority_tick_scheduler_unit #(
    parameter int MAX_PROCS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: slot_index[3:0], arrival_time[19:4], burst_time[35:20], zero fill
    input  logic [apts_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [apts_pkg::OP_W-1:0]           i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: served_slot[3:0], tick_time[27:4], wait_of_finished[51:28],
    //        total_wait[83:52], all_done[84], zero fill
    output logic [apts_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // tuser: ran[0], finished[1]
    output logic [apts_pkg::OUT_TUSER_W-1:0]    o_m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [apts_pkg::COUNT_W-1:0]        i_cfg_data
);

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int ROW_W = $bits(apts_pkg::t_row);

    apts_pkg::t_state                r_state, n_state;

    logic [apts_pkg::COUNT_W-1:0]    r_pcount;
    logic [MAX_PROCS-1:0]            r_valid;
    logic [MAX_PROCS-1:0]            r_busy;
    logic [apts_pkg::TIME_W-1:0]     r_time;
    logic [apts_pkg::PRIO_W-1:0]     r_max;
    logic [apts_pkg::PRIO_W-1:0]     r_newmax;
    logic [apts_pkg::SUM_W-1:0]      r_wsum;
    logic [apts_pkg::OP_W-1:0]       r_op;
    logic [IW-1:0]                   r_idx;
    logic                            r_taken;
    logic [IW-1:0]                   r_served;
    logic                            r_fin;
    logic [apts_pkg::TIME_W-1:0]     r_wait;

    logic                            r_ovalid;
    logic [apts_pkg::OUT_TDATA_W-1:0] r_odata;
    logic [apts_pkg::OUT_TUSER_W-1:0] r_ouser;

    logic                            w_in_acc;
    logic                            w_out_free;
    logic [IW-1:0]                   w_last;
    logic [MAX_PROCS-1:0]            w_used;
    logic                            w_all_done;
    logic [apts_pkg::SLOT_W-1:0]     w_in_slot;
    logic [apts_pkg::BURST_W-1:0]    w_in_arr;
    logic [apts_pkg::BURST_W-1:0]    w_in_bur;
    logic                            w_load_ok;

    logic                            w_re;
    logic [IW-1:0]                   w_raddr;
    logic                            w_we;
    logic [IW-1:0]                   w_waddr;
    apts_pkg::t_row                  w_wrow;
    logic [ROW_W-1:0]                w_rdata;
    apts_pkg::t_row                  w_row;
    apts_pkg::t_slot_res             w_res;
    logic [apts_pkg::PRIO_W-1:0]     w_newmax;
    logic [apts_pkg::SUM_W:0]        w_sum_ext;
    logic [apts_pkg::SUM_W-1:0]      w_wsum_next;

    assign w_in_slot  = i_s_axis_tdata[3:0];
    assign w_in_arr   = i_s_axis_tdata[19:4];
    assign w_in_bur   = i_s_axis_tdata[35:20];
    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_ovalid || i_m_axis_tready;
    assign w_load_ok  = (32'(w_in_slot) < MAX_PROCS);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_pcount == '0) begin
            w_last = '0;
        end else if (32'(r_pcount) > MAX_PROCS) begin
            w_last = IW'(MAX_PROCS - 1);
        end else begin
            w_last = IW'(r_pcount - apts_pkg::COUNT_W'(1));
        end
        for (int k = 0; k < MAX_PROCS; k++) begin
            w_used[k] = (IW'(k) <= w_last);
        end
        w_all_done = ~|(r_busy & w_used);
    end

    apts_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_PROCS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wrow),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_row = r_valid[r_idx] ? apts_pkg::t_row'(w_rdata) : '0;

    apts_slot_alu u_alu (
        .i_row   (w_row),
        .i_time  (r_time),
        .i_max   (r_max),
        .i_taken (r_taken),
        .o_res   (w_res)
    );

    assign w_newmax = ((r_idx == '0) || (w_res.prio_next > r_newmax)) ? w_res.prio_next
                                                                       : r_newmax;
    assign w_sum_ext = {1'b0, r_wsum} + (apts_pkg::SUM_W+1)'(r_wait);

    always_comb begin
        if (r_op == apts_pkg::OP_RESTART) begin
            w_wsum_next = '0;
        end else if (r_fin) begin
            w_wsum_next = w_sum_ext[apts_pkg::SUM_W] ? '1 : w_sum_ext[apts_pkg::SUM_W-1:0];
        end else begin
            w_wsum_next = r_wsum;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            apts_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_s_axis_tuser == apts_pkg::OP_TICK) ? apts_pkg::ST_FETCH
                                                                     : apts_pkg::ST_DONE;
                end
            end
            apts_pkg::ST_FETCH: begin
                n_state = apts_pkg::ST_EXEC;
            end
            apts_pkg::ST_EXEC: begin
                if (r_idx == w_last) begin
                    n_state = apts_pkg::ST_DONE;
                end
            end
            apts_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = apts_pkg::ST_IDLE;
                end
            end
            default: n_state = apts_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        w_re    = 1'b0;
        w_raddr = '0;
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wrow  = '0;
        unique case (r_state)
            apts_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                w_waddr = IW'(w_in_slot);
                w_wrow.arrival   = w_in_arr;
                w_wrow.burst     = w_in_bur;
                w_wrow.remaining = w_in_bur;
                w_wrow.prio      = '0;
                w_we = w_in_acc && (i_s_axis_tuser == apts_pkg::OP_LOAD) && w_load_ok;
            end
            apts_pkg::ST_FETCH: begin
                w_re = 1'b1;
            end
            apts_pkg::ST_EXEC: begin
                w_re    = (r_idx != w_last);
                w_raddr = r_idx + IW'(1);
                w_we    = w_res.ready;
                w_wrow.arrival   = w_row.arrival;
                w_wrow.burst     = w_row.burst;
                w_wrow.remaining = w_res.rem_next;
                w_wrow.prio      = w_res.prio_next;
            end
            apts_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= apts_pkg::ST_IDLE;
            r_pcount <= apts_pkg::COUNT_W'(1);
            r_valid  <= '0;
            r_busy   <= '0;
            r_time   <= '0;
            r_max    <= '0;
            r_wsum   <= '0;
            r_ovalid <= 1'b0;
            r_op     <= apts_pkg::OP_LOAD;
            r_idx    <= '0;
            r_taken  <= 1'b0;
            r_fin    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pcount <= i_cfg_data;
            end
            if ((r_state == apts_pkg::ST_DONE) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                apts_pkg::ST_IDLE: begin
                    if (w_in_acc) begin
                        r_op    <= i_s_axis_tuser;
                        r_idx   <= '0;
                        r_taken <= 1'b0;
                        r_fin   <= 1'b0;
                        r_served <= '0;
                        r_wait  <= '0;
                        if ((i_s_axis_tuser == apts_pkg::OP_LOAD) && w_load_ok) begin
                            r_valid[IW'(w_in_slot)] <= 1'b1;
                            r_busy[IW'(w_in_slot)]  <= (w_in_bur != '0);
                        end
                    end
                end
                apts_pkg::ST_FETCH: begin
                end
                apts_pkg::ST_EXEC: begin
                    r_newmax <= w_newmax;
                    if (w_res.serve) begin
                        r_taken  <= 1'b1;
                        r_served <= r_idx;
                        r_fin    <= w_res.fin;
                        r_wait   <= w_res.fin ? w_res.wait_val : '0;
                        if (w_res.fin) begin
                            r_busy[r_idx] <= 1'b0;
                        end
                    end
                    if (r_idx == w_last) begin
                        r_max <= w_newmax;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                apts_pkg::ST_DONE: begin
                    if (w_out_free) begin
                        r_wsum   <= w_wsum_next;
                        if (r_op == apts_pkg::OP_RESTART) begin
                            r_time <= '0;
                            r_max  <= '0;
                        end else if ((r_op == apts_pkg::OP_TICK) &&
                                     (r_time != apts_pkg::TIME_MAX)) begin
                            r_time <= r_time + apts_pkg::TIME_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == apts_pkg::ST_DONE) && w_out_free) begin
            r_odata <= {3'b000, w_all_done, w_wsum_next, r_wait, r_time,
                        apts_pkg::SLOT_W'(r_served)};
            r_ouser <= {r_fin, r_taken};
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

endmodule

/* sv/apts_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Parameters set word width and depth. No dependencies.
module apts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/apts_slot_alu.sv */
// Per-slot update unit shared by every step of a tick pass.
// Decides readiness and service, ages the priority, and forms the wait of a finished process.
// Depends on apts_pkg.
module apts_slot_alu (
    input  apts_pkg::t_row                      i_row,
    input  logic [apts_pkg::TIME_W-1:0]         i_time,
    input  logic [apts_pkg::PRIO_W-1:0]         i_max,
    input  logic                                i_taken,
    output apts_pkg::t_slot_res                 o_res
);

    logic                            w_ready;
    logic                            w_serve;
    logic [apts_pkg::PRIO_W:0]       w_sum;
    logic [apts_pkg::BURST_W-1:0]    w_rem_dec;
    logic [apts_pkg::TIME_W:0]       w_lhs;
    logic [apts_pkg::TIME_W:0]       w_rhs;
    logic [apts_pkg::TIME_W:0]       w_diff;
    logic [apts_pkg::TIME_W-1:0]     w_wait;

    always_comb begin
        w_ready   = (i_time >= apts_pkg::TIME_W'(i_row.arrival)) && (i_row.remaining != '0);
        w_serve   = w_ready && !i_taken && (i_row.prio == i_max);
        w_sum     = {1'b0, i_row.prio} + (w_serve ? (apts_pkg::PRIO_W+1)'(1)
                                                  : (apts_pkg::PRIO_W+1)'(2));
        w_rem_dec = i_row.remaining - apts_pkg::BURST_W'(1);
        w_lhs     = {1'b0, i_time} + (apts_pkg::TIME_W+1)'(1);
        w_rhs     = (apts_pkg::TIME_W+1)'(i_row.arrival) + (apts_pkg::TIME_W+1)'(i_row.burst);
        w_diff    = w_lhs - w_rhs;
        if (w_lhs <= w_rhs) begin
            w_wait = '0;
        end else if (w_diff[apts_pkg::TIME_W]) begin
            w_wait = apts_pkg::TIME_MAX;
        end else begin
            w_wait = w_diff[apts_pkg::TIME_W-1:0];
        end

        o_res.ready     = w_ready;
        o_res.serve     = w_serve;
        o_res.fin       = w_serve && (w_rem_dec == '0);
        o_res.rem_next  = w_serve ? w_rem_dec : i_row.remaining;
        o_res.wait_val  = w_wait;
        if (!w_ready) begin
            o_res.prio_next = i_row.prio;
        end else if (w_sum[apts_pkg::PRIO_W]) begin
            o_res.prio_next = '1;
        end else begin
            o_res.prio_next = w_sum[apts_pkg::PRIO_W-1:0];
        end
    end

endmodule

/* sv/apts_checker.sv */
// Port-level checker for the aging priority tick scheduler, bound to the top level.
// Depends on apts_pkg and aging_priority_tick_scheduler_unit.
module apts_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_s_axis_tvalid,
    input logic                                 o_s_axis_tready,
    input logic                                 o_m_axis_tvalid,
    input logic                                 i_m_axis_tready,
    input logic [apts_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    input logic [apts_pkg::OUT_TUSER_W-1:0]     o_m_axis_tuser
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output word changed while stalled");

    // The block works on one command word at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // Without service there is no finish and no served slot.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |->
        !o_m_axis_tuser[1] && (o_m_axis_tdata[3:0] == 4'd0))
        else $error("idle result reports a served or finished slot");

    // A wait value is reported only for a finished process.
    a_wait_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[1] |-> (o_m_axis_tdata[51:28] == 24'd0))
        else $error("wait reported without a finished process");

endmodule

bind aging_priority_tick_scheduler_unit apts_checker u_apts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
